// ===== sv/pr2d_pkg.sv =====
// Package for the 2-D point rotation block.
// Holds the angle-reduction constants, the CORDIC gain and the arctangent table.
// No dependencies.
package pr2d_pkg;

  // Angle input format: 1/128 degree, signed.
  localparam int ANGLE_WIDTH         = 17;
  localparam int HALF_TURN_DEG       = 180;
  localparam int ANGLE_UNITS_PER_DEG = 128;
  localparam int FULL_TURN           = 2 * HALF_TURN_DEG * ANGLE_UNITS_PER_DEG;

  // Reduced angle in [0, FULL_TURN) and its split into 45 * q + s.
  localparam int REDUCED_WIDTH = 16;
  localparam int DIV_BASE      = 45;
  localparam int RECIP_45      = 46604;   // ceil(2^21 / 45)
  localparam int RECIP_SHIFT   = 21;
  localparam int QUOT_WIDTH    = 10;
  localparam int REM_WIDTH     = 6;
  localparam int QUOT_SHIFT    = 22;      // binary angle = r * 2^22 / 45
  localparam int REM_STEP      = 93206;   // floor(2^22 / 45)

  // Binary angle: a full turn is 2^32.
  localparam int BAM_WIDTH = 32;
  localparam logic signed [BAM_WIDTH-1:0] QUARTER_BAM     = 32'sh4000_0000;
  localparam logic signed [BAM_WIDTH-1:0] NEG_QUARTER_BAM = 32'shC000_0000;

  // CORDIC gain compensation, 0.60725293500888 in Q30.
  localparam int GAIN_FRAC   = 30;
  localparam logic signed [GAIN_FRAC:0] GAIN_Q30 = 31'sd652032874;

  // Guard bits kept beyond the output fraction bits.
  localparam int GUARD_EXTRA = 12;

  localparam int ATAN_ENTRIES = 24;

  // Rounding correction for floor((s * 2^22 + 22) / 45) - s * REM_STEP.
  function automatic logic [REM_WIDTH-1:0] rem_corr(input logic [REM_WIDTH-1:0] s);
    logic [REM_WIDTH-1:0] c;
    case (s)
      6'd0:  c = 6'd0;   6'd1:  c = 6'd1;   6'd2:  c = 6'd2;   6'd3:  c = 6'd2;
      6'd4:  c = 6'd3;   6'd5:  c = 6'd4;   6'd6:  c = 6'd5;   6'd7:  c = 6'd5;
      6'd8:  c = 6'd6;   6'd9:  c = 6'd7;   6'd10: c = 6'd8;   6'd11: c = 6'd8;
      6'd12: c = 6'd9;   6'd13: c = 6'd10;  6'd14: c = 6'd11;  6'd15: c = 6'd11;
      6'd16: c = 6'd12;  6'd17: c = 6'd13;  6'd18: c = 6'd14;  6'd19: c = 6'd14;
      6'd20: c = 6'd15;  6'd21: c = 6'd16;  6'd22: c = 6'd17;  6'd23: c = 6'd17;
      6'd24: c = 6'd18;  6'd25: c = 6'd19;  6'd26: c = 6'd20;  6'd27: c = 6'd20;
      6'd28: c = 6'd21;  6'd29: c = 6'd22;  6'd30: c = 6'd23;  6'd31: c = 6'd23;
      6'd32: c = 6'd24;  6'd33: c = 6'd25;  6'd34: c = 6'd26;  6'd35: c = 6'd26;
      6'd36: c = 6'd27;  6'd37: c = 6'd28;  6'd38: c = 6'd29;  6'd39: c = 6'd29;
      6'd40: c = 6'd30;  6'd41: c = 6'd31;  6'd42: c = 6'd32;  6'd43: c = 6'd32;
      6'd44: c = 6'd33;
      default: c = '0;
    endcase
    return c;
  endfunction

  // atan(2^-i) as a binary angle.
  function automatic logic [BAM_WIDTH-1:0] atan_bam(input logic [4:0] idx);
    logic [BAM_WIDTH-1:0] v;
    case (idx)
      5'd0:  v = 32'h2000_0000;  5'd1:  v = 32'h12E4_051E;
      5'd2:  v = 32'h09FB_385B;  5'd3:  v = 32'h0511_11D4;
      5'd4:  v = 32'h028B_0D43;  5'd5:  v = 32'h0145_D7E1;
      5'd6:  v = 32'h00A2_F61E;  5'd7:  v = 32'h0051_7C55;
      5'd8:  v = 32'h0028_BE53;  5'd9:  v = 32'h0014_5F2F;
      5'd10: v = 32'h000A_2F98;  5'd11: v = 32'h0005_17CC;
      5'd12: v = 32'h0002_8BE6;  5'd13: v = 32'h0001_45F3;
      5'd14: v = 32'h0000_A2FA;  5'd15: v = 32'h0000_517D;
      5'd16: v = 32'h0000_28BE;  5'd17: v = 32'h0000_145F;
      5'd18: v = 32'h0000_0A30;  5'd19: v = 32'h0000_0518;
      5'd20: v = 32'h0000_028C;  5'd21: v = 32'h0000_0146;
      5'd22: v = 32'h0000_00A3;  5'd23: v = 32'h0000_0051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/pr2d_angle_reduce.sv =====
// Angle front end: reduces the degree angle modulo one turn and converts it
// to a 32-bit binary angle over four pipeline stages. Uses pr2d_pkg.
module pr2d_angle_reduce #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    valid_i,
  output logic                                    ready_o,
  input  logic signed [COORD_WIDTH-1:0]           x_i,
  input  logic signed [COORD_WIDTH-1:0]           y_i,
  input  logic signed [pr2d_pkg::ANGLE_WIDTH-1:0] angle_i,
  output logic                                    valid_o,
  input  logic                                    ready_i,
  output logic signed [COORD_WIDTH-1:0]           x_o,
  output logic signed [COORD_WIDTH-1:0]           y_o,
  output logic signed [pr2d_pkg::BAM_WIDTH-1:0]   z_o
);

  localparam int AW = pr2d_pkg::ANGLE_WIDTH;
  localparam int RW = pr2d_pkg::REDUCED_WIDTH;
  localparam int QW = pr2d_pkg::QUOT_WIDTH;
  localparam int SW = pr2d_pkg::REM_WIDTH;
  localparam int BW = pr2d_pkg::BAM_WIDTH;
  localparam logic signed [AW:0] FULL_S  = (AW+1)'(pr2d_pkg::FULL_TURN);
  localparam logic signed [AW:0] FULL2_S = (AW+1)'(2 * pr2d_pkg::FULL_TURN);

  // Stage 1: reduce into [0, full turn).
  logic                          s1_valid_q, s1_rdy;
  logic signed [COORD_WIDTH-1:0] s1_x_q, s1_y_q;
  logic [RW-1:0]                 s1_r_q;
  logic signed [AW:0]            a_ext, r_ext;

  // Stage 2: quotient by 45 through the reciprocal.
  logic                          s2_valid_q, s2_rdy;
  logic signed [COORD_WIDTH-1:0] s2_x_q, s2_y_q;
  logic [RW-1:0]                 s2_r_q;
  logic [QW-1:0]                 s2_q_q;
  logic [2*RW-1:0]               recip_prod;

  // Stage 3: remainder.
  logic                          s3_valid_q, s3_rdy;
  logic signed [COORD_WIDTH-1:0] s3_x_q, s3_y_q;
  logic [QW-1:0]                 s3_q_q;
  logic [SW-1:0]                 s3_s_q;
  logic [RW-1:0]                 quot_mul, rem_full;

  // Stage 4: binary angle.
  logic                          s4_valid_q, s4_rdy;
  logic signed [COORD_WIDTH-1:0] s4_x_q, s4_y_q;
  logic signed [BW-1:0]          s4_z_q;
  logic [BW-1:0]                 bam_d;

  assign s4_rdy  = !s4_valid_q || ready_i;
  assign s3_rdy  = !s3_valid_q || s4_rdy;
  assign s2_rdy  = !s2_valid_q || s3_rdy;
  assign s1_rdy  = !s1_valid_q || s2_rdy;
  assign ready_o = s1_rdy;

  always_comb begin
    a_ext = $signed({angle_i[AW-1], angle_i});
    if (a_ext >= FULL_S) begin
      r_ext = a_ext - FULL_S;
    end else if (a_ext >= 0) begin
      r_ext = a_ext;
    end else if (a_ext >= -FULL_S) begin
      r_ext = a_ext + FULL_S;
    end else begin
      r_ext = a_ext + FULL2_S;
    end
  end

  assign recip_prod = (2*RW)'(s1_r_q) * (2*RW)'(pr2d_pkg::RECIP_45);
  assign quot_mul   = RW'(s2_q_q) * RW'(pr2d_pkg::DIV_BASE);
  assign rem_full   = s2_r_q - quot_mul;
  assign bam_d      = {s3_q_q, {pr2d_pkg::QUOT_SHIFT{1'b0}}}
                    + BW'(s3_s_q) * BW'(pr2d_pkg::REM_STEP)
                    + BW'(pr2d_pkg::rem_corr(s3_s_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      if (s1_rdy) s1_valid_q <= valid_i;
      if (s2_rdy) s2_valid_q <= s1_valid_q;
      if (s3_rdy) s3_valid_q <= s2_valid_q;
      if (s4_rdy) s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy && valid_i) begin
      s1_x_q <= x_i;
      s1_y_q <= y_i;
      s1_r_q <= r_ext[RW-1:0];
    end
    if (s2_rdy && s1_valid_q) begin
      s2_x_q <= s1_x_q;
      s2_y_q <= s1_y_q;
      s2_r_q <= s1_r_q;
      s2_q_q <= recip_prod[pr2d_pkg::RECIP_SHIFT +: QW];
    end
    if (s3_rdy && s2_valid_q) begin
      s3_x_q <= s2_x_q;
      s3_y_q <= s2_y_q;
      s3_q_q <= s2_q_q;
      s3_s_q <= rem_full[SW-1:0];
    end
    if (s4_rdy && s3_valid_q) begin
      s4_x_q <= s3_x_q;
      s4_y_q <= s3_y_q;
      s4_z_q <= $signed(bam_d);
    end
  end

  assign valid_o = s4_valid_q;
  assign x_o     = s4_x_q;
  assign y_o     = s4_y_q;
  assign z_o     = s4_z_q;

endmodule

// ===== sv/pr2d_prescale.sv =====
// Quadrant fold and gain compensation ahead of the CORDIC stages.
// Two pipeline stages. Uses pr2d_pkg.
module pr2d_prescale #(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS   = 8
) (
  input  logic                                                clk_i,
  input  logic                                                rst_ni,
  input  logic                                                valid_i,
  output logic                                                ready_o,
  input  logic signed [COORD_WIDTH-1:0]                       x_i,
  input  logic signed [COORD_WIDTH-1:0]                       y_i,
  input  logic signed [pr2d_pkg::BAM_WIDTH-1:0]               z_i,
  output logic                                                valid_o,
  input  logic                                                ready_i,
  output logic signed [COORD_WIDTH+FRAC_BITS+pr2d_pkg::GUARD_EXTRA+1:0] x_o,
  output logic signed [COORD_WIDTH+FRAC_BITS+pr2d_pkg::GUARD_EXTRA+1:0] y_o,
  output logic signed [pr2d_pkg::BAM_WIDTH-1:0]               z_o
);

  localparam int BW = pr2d_pkg::BAM_WIDTH;
  localparam int EW = COORD_WIDTH + 1;
  localparam int DW = COORD_WIDTH + FRAC_BITS + pr2d_pkg::GUARD_EXTRA + 2;
  localparam int PW = EW + pr2d_pkg::GAIN_FRAC + 1;
  localparam int SH = pr2d_pkg::GAIN_FRAC - pr2d_pkg::GUARD_EXTRA - FRAC_BITS;

  logic                 p1_valid_q, p1_rdy;
  logic signed [EW-1:0] p1_x_q, p1_y_q;
  logic signed [BW-1:0] p1_z_q;
  logic signed [EW-1:0] x_ext, y_ext;
  logic                 beyond_quarter;

  logic                 p2_valid_q, p2_rdy;
  logic signed [DW-1:0] p2_x_q, p2_y_q;
  logic signed [BW-1:0] p2_z_q;
  logic signed [PW-1:0] prod_x, prod_y;

  assign p2_rdy  = !p2_valid_q || ready_i;
  assign p1_rdy  = !p1_valid_q || p2_rdy;
  assign ready_o = p1_rdy;

  // Outside plus or minus ninety degrees the point is negated and half a
  // turn comes off the angle, which in 32-bit wraparound is a flip of the MSB.
  assign beyond_quarter = (z_i > pr2d_pkg::QUARTER_BAM) || (z_i < pr2d_pkg::NEG_QUARTER_BAM);
  assign x_ext          = $signed({x_i[COORD_WIDTH-1], x_i});
  assign y_ext          = $signed({y_i[COORD_WIDTH-1], y_i});

  assign prod_x = PW'(p1_x_q) * PW'(pr2d_pkg::GAIN_Q30);
  assign prod_y = PW'(p1_y_q) * PW'(pr2d_pkg::GAIN_Q30);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
    end else begin
      if (p1_rdy) p1_valid_q <= valid_i;
      if (p2_rdy) p2_valid_q <= p1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p1_rdy && valid_i) begin
      p1_x_q <= beyond_quarter ? -x_ext : x_ext;
      p1_y_q <= beyond_quarter ? -y_ext : y_ext;
      p1_z_q <= beyond_quarter ? $signed({~z_i[BW-1], z_i[BW-2:0]}) : z_i;
    end
    if (p2_rdy && p1_valid_q) begin
      p2_x_q <= prod_x[SH +: DW];
      p2_y_q <= prod_y[SH +: DW];
      p2_z_q <= p1_z_q;
    end
  end

  assign valid_o = p2_valid_q;
  assign x_o     = p2_x_q;
  assign y_o     = p2_y_q;
  assign z_o     = p2_z_q;

endmodule

// ===== sv/pr2d_cordic_stage.sv =====
// One CORDIC rotation iteration as a single pipeline stage.
// Uses the arctangent table in pr2d_pkg.
module pr2d_cordic_stage #(
  parameter int DATA_WIDTH = 38,
  parameter int STAGE_IDX  = 0
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  logic signed [DATA_WIDTH-1:0]          x_i,
  input  logic signed [DATA_WIDTH-1:0]          y_i,
  input  logic signed [pr2d_pkg::BAM_WIDTH-1:0] z_i,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output logic signed [DATA_WIDTH-1:0]          x_o,
  output logic signed [DATA_WIDTH-1:0]          y_o,
  output logic signed [pr2d_pkg::BAM_WIDTH-1:0] z_o
);

  localparam int BW = pr2d_pkg::BAM_WIDTH;
  localparam logic signed [BW-1:0] ATAN = $signed(pr2d_pkg::atan_bam(5'(STAGE_IDX)));

  logic                         valid_q, rdy;
  logic signed [DATA_WIDTH-1:0] x_q, y_q, xs, ys;
  logic signed [BW-1:0]         z_q;
  logic                         rotate_pos;

  assign rdy        = !valid_q || ready_i;
  assign ready_o    = rdy;
  assign xs         = x_i >>> STAGE_IDX;
  assign ys         = y_i >>> STAGE_IDX;
  assign rotate_pos = !z_i[BW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (rdy) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy && valid_i) begin
      x_q <= rotate_pos ? x_i - ys : x_i + ys;
      y_q <= rotate_pos ? y_i + xs : y_i - xs;
      z_q <= rotate_pos ? z_i - ATAN : z_i + ATAN;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;

endmodule

// ===== sv/pr2d_round.sv =====
// Output stage: rounds the CORDIC result to the output fraction bits,
// ties toward plus infinity, into the output register. Uses pr2d_pkg.
module pr2d_round #(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS   = 8
) (
  input  logic                                                clk_i,
  input  logic                                                rst_ni,
  input  logic                                                valid_i,
  output logic                                                ready_o,
  input  logic signed [COORD_WIDTH+FRAC_BITS+pr2d_pkg::GUARD_EXTRA+1:0] x_i,
  input  logic signed [COORD_WIDTH+FRAC_BITS+pr2d_pkg::GUARD_EXTRA+1:0] y_i,
  output logic                                                valid_o,
  input  logic                                                ready_i,
  output logic signed [COORD_WIDTH+FRAC_BITS:0]               x_o,
  output logic signed [COORD_WIDTH+FRAC_BITS:0]               y_o
);

  localparam int GE = pr2d_pkg::GUARD_EXTRA;
  localparam int DW = COORD_WIDTH + FRAC_BITS + GE + 2;
  localparam int OW = COORD_WIDTH + FRAC_BITS + 1;
  localparam logic signed [DW:0] HALF_LSB = (DW+1)'(1) << (GE - 1);

  logic                 valid_q, rdy;
  logic signed [OW-1:0] x_q, y_q;
  logic signed [DW:0]   x_sum, y_sum;

  assign rdy     = !valid_q || ready_i;
  assign ready_o = rdy;
  assign x_sum   = $signed({x_i[DW-1], x_i}) + HALF_LSB;
  assign y_sum   = $signed({y_i[DW-1], y_i}) + HALF_LSB;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (rdy) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy && valid_i) begin
      x_q <= x_sum[GE +: OW];
      y_q <= y_sum[GE +: OW];
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;

endmodule

// ===== sv/point_rotation_2d.sv =====
// Top level of the 2-D point rotation block.
// Instantiates pr2d_angle_reduce, pr2d_prescale, pr2d_cordic_stage and pr2d_round.
//
// Rotates a signed integer point counterclockwise about the origin by an angle
// in 1/128 degree, reduced modulo 360 degrees, and returns x*cos - y*sin and
// x*sin + y*cos with FRAC_BITS fraction bits, rounded to nearest. The block is
// a fully pipelined CORDIC: it accepts one point per clock cycle while the
// output is not held, and each point passes through four stages of angle
// reduction, two of quadrant fold and gain multiply, one per CORDIC iteration
// and one of rounding into the output register. Every stage stalls only when
// it holds a beat that the next stage cannot take, so empty stages keep
// filling while the output waits. The block holds no state between points.
module point_rotation_2d #(
  parameter int COORD_WIDTH    = 16,
  parameter int FRAC_BITS      = 8,
  parameter int ROT_ITERATIONS = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic signed [COORD_WIDTH-1:0]           point_x_i,
  input  logic signed [COORD_WIDTH-1:0]           point_y_i,
  input  logic signed [pr2d_pkg::ANGLE_WIDTH-1:0] angle_deg_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic signed [COORD_WIDTH+FRAC_BITS:0]   rotated_x_o,
  output logic signed [COORD_WIDTH+FRAC_BITS:0]   rotated_y_o
);

  localparam int BW = pr2d_pkg::BAM_WIDTH;
  localparam int DW = COORD_WIDTH + FRAC_BITS + pr2d_pkg::GUARD_EXTRA + 2;

  logic                          ar_valid, ar_ready;
  logic signed [COORD_WIDTH-1:0] ar_x, ar_y;
  logic signed [BW-1:0]          ar_z;

  logic                 cs_valid [0:ROT_ITERATIONS];
  logic                 cs_ready [0:ROT_ITERATIONS];
  logic signed [DW-1:0] cs_x     [0:ROT_ITERATIONS];
  logic signed [DW-1:0] cs_y     [0:ROT_ITERATIONS];
  logic signed [BW-1:0] cs_z     [0:ROT_ITERATIONS];

  pr2d_angle_reduce #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_angle (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .x_i     (point_x_i),
    .y_i     (point_y_i),
    .angle_i (angle_deg_i),
    .valid_o (ar_valid),
    .ready_i (ar_ready),
    .x_o     (ar_x),
    .y_o     (ar_y),
    .z_o     (ar_z)
  );

  pr2d_prescale #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_prescale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ar_valid),
    .ready_o (ar_ready),
    .x_i     (ar_x),
    .y_i     (ar_y),
    .z_i     (ar_z),
    .valid_o (cs_valid[0]),
    .ready_i (cs_ready[0]),
    .x_o     (cs_x[0]),
    .y_o     (cs_y[0]),
    .z_o     (cs_z[0])
  );

  for (genvar i = 0; i < ROT_ITERATIONS; i++) begin : g_iter
    pr2d_cordic_stage #(
      .DATA_WIDTH(DW),
      .STAGE_IDX (i)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cs_valid[i]),
      .ready_o (cs_ready[i]),
      .x_i     (cs_x[i]),
      .y_i     (cs_y[i]),
      .z_i     (cs_z[i]),
      .valid_o (cs_valid[i+1]),
      .ready_i (cs_ready[i+1]),
      .x_o     (cs_x[i+1]),
      .y_o     (cs_y[i+1]),
      .z_o     (cs_z[i+1])
    );
  end

  pr2d_round #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cs_valid[ROT_ITERATIONS]),
    .ready_o (cs_ready[ROT_ITERATIONS]),
    .x_i     (cs_x[ROT_ITERATIONS]),
    .y_i     (cs_y[ROT_ITERATIONS]),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .x_o     (rotated_x_o),
    .y_o     (rotated_y_o)
  );

endmodule
